/* rtl/core/teg_pkg.sv */
// ----------------------------------------------------------------------------
// teg_pkg
// Shared types and constants for the tone envelope generator core.
// ----------------------------------------------------------------------------
package teg_pkg;

  localparam int unsigned CfgDataW = 48;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PLAY = 2'd1,
    CMD_END  = 2'd2
  } teg_cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_STEP    = 3'd0,
    REG_START_SLIDE   = 3'd1,
    REG_SLIDE_DELTA   = 3'd2,
    REG_STAGE_TIMES   = 3'd3,
    REG_STAGE_SLOPES  = 3'd4,
    REG_RETRIG_LIMITS = 3'd5,
    REG_REPEAT_LIMIT  = 3'd6
  } teg_reg_t;

  localparam logic [1:0] STAGE_ATTACK  = 2'd0;
  localparam logic [1:0] STAGE_SUSTAIN = 2'd1;
  localparam logic [1:0] STAGE_DECAY   = 2'd2;

  localparam logic [7:0] LEVEL_MIN      = 8'd3;
  localparam logic [7:0] LEVEL_MAX      = 8'd255;
  localparam logic [7:0] REPEAT_FOREVER = 8'hFF;

  typedef struct packed {
    logic        half_period_done;
    logic [15:0] half_period_ticks;
    logic [7:0]  duty;
    logic        playing;
    logic        note_done;
  } teg_result_t;

endpackage

/* rtl/core/tone_envelope_generator_core.sv */
// ----------------------------------------------------------------------------
// tone_envelope_generator_core
// Square-wave tone with slide and a three-stage envelope, one step per
// transaction, with a two-entry registered result buffer.
// ----------------------------------------------------------------------------
// a result is registered into the head or skid entry when its input transaction is taken
// throughput: one transaction per cycle while in_stall is low; all state updates in one pass of logic
// in_stall is high while both result entries are full, i.e. after out_stall held a waiting head
// reset (rst_n low, synchronous) clears the note state and the configuration
// registers and empties both result entries; cfg_ready is always high
module tone_envelope_generator_core
  import teg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_priority_req,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_half_period_done,
  output logic [15:0]         out_half_period_ticks,
  output logic [7:0]          out_duty,
  output logic                out_playing,
  output logic                out_note_done,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // configuration registers
  logic [15:0] start_step_r;
  logic [31:0] start_slide_r, slide_delta_r, retrig_r;
  logic [47:0] stage_times_r, stage_slopes_r;
  logic [7:0]  repeat_limit_r;

  // note state
  logic        active_r, active_nxt;
  logic [7:0]  held_prio_r, held_prio_nxt;
  logic [15:0] phase_r, phase_nxt;
  logic [31:0] step_r, step_nxt;
  logic [31:0] slide_r, slide_nxt;
  logic [7:0]  level_r, level_nxt;
  logic [15:0] amp_r, amp_nxt;
  logic [15:0] slope_r, slope_nxt;
  logic [15:0] stage_sum_r, stage_sum_nxt;
  logic [15:0] target_r, target_nxt;
  logic [1:0]  stage_idx_r, stage_idx_nxt;
  logic [7:0]  repeat_r, repeat_nxt;
  logic [15:0] half_r, half_nxt;

  // result buffer
  logic        head_v_r, head_v_nxt, skid_v_r, skid_v_nxt;
  teg_result_t head_r, head_nxt, skid_r, skid_nxt;
  teg_result_t res;

  logic push, pop, cfg_we;

  // step temporaries
  logic        restart_freq, restart_sound, amp_step, ended, hp_done;
  logic [15:0] phase_sum, half_inc, tick_sum, amp_sum, retrig_lo, retrig_hi;
  logic [31:0] step_sum;
  logic [1:0]  idx_inc;
  logic [7:0]  rep_inc;

  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = skid_v_r;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign retrig_lo = retrig_r[15:0];
  assign retrig_hi = retrig_r[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_step_r   <= '0;
      start_slide_r  <= '0;
      slide_delta_r  <= '0;
      stage_times_r  <= '0;
      stage_slopes_r <= '0;
      retrig_r       <= '0;
      repeat_limit_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_STEP:    start_step_r   <= cfg_data[15:0];
        REG_START_SLIDE:   start_slide_r  <= cfg_data[31:0];
        REG_SLIDE_DELTA:   slide_delta_r  <= cfg_data[31:0];
        REG_STAGE_TIMES:   stage_times_r  <= cfg_data[47:0];
        REG_STAGE_SLOPES:  stage_slopes_r <= cfg_data[47:0];
        REG_RETRIG_LIMITS: retrig_r       <= cfg_data[31:0];
        REG_REPEAT_LIMIT:  repeat_limit_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    active_nxt    = active_r;
    held_prio_nxt = held_prio_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    slide_nxt     = slide_r;
    level_nxt     = level_r;
    amp_nxt       = amp_r;
    slope_nxt     = slope_r;
    stage_sum_nxt = stage_sum_r;
    target_nxt    = target_r;
    stage_idx_nxt = stage_idx_r;
    repeat_nxt    = repeat_r;
    half_nxt      = half_r;
    restart_freq  = 1'b0;
    restart_sound = 1'b0;
    amp_step      = 1'b0;
    ended         = 1'b0;
    hp_done       = 1'b0;
    phase_sum     = phase_r + step_r[31:16];
    step_sum      = step_r + {{8{slide_r[31]}}, slide_r[31:8]};
    half_inc      = half_r + 16'd1;
    tick_sum      = stage_sum_r + half_inc;
    idx_inc       = stage_idx_r + 2'd1;
    rep_inc       = repeat_r + 8'd1;
    amp_sum       = '0;

    if (push) begin
      unique case (in_command)
        CMD_PLAY: begin
          if (held_prio_r < in_priority_req) begin
            held_prio_nxt = in_priority_req;
            active_nxt    = 1'b1;
            restart_sound = 1'b1;
            repeat_nxt    = '0;
          end
        end
        CMD_END: begin
          ended         = active_r;
          held_prio_nxt = '0;
          active_nxt    = 1'b0;
        end
        CMD_TICK: begin
          if (active_r) begin
            amp_step  = 1'b1;
            phase_nxt = phase_sum;
            step_nxt  = step_sum;
            slide_nxt = slide_r + slide_delta_r;
            half_nxt  = half_inc;
            // phase wrap closes a half period
            if (phase_sum < step_sum[31:16]) begin
              hp_done       = 1'b1;
              stage_sum_nxt = tick_sum;
              half_nxt      = '0;
              restart_freq  = (retrig_lo != '0 && step_sum[31:16] <= retrig_lo) ||
                              (retrig_hi != '0 && step_sum[31:16] >= retrig_hi);
              if (tick_sum >= target_r) begin
                stage_idx_nxt = idx_inc;
                stage_sum_nxt = '0;
                if (idx_inc == STAGE_SUSTAIN) begin
                  level_nxt  = LEVEL_MAX;
                  target_nxt = stage_times_r[31:16];
                  slope_nxt  = stage_slopes_r[31:16];
                end else if (idx_inc == STAGE_DECAY) begin
                  target_nxt = stage_times_r[47:32];
                  slope_nxt  = stage_slopes_r[47:32];
                end else begin
                  repeat_nxt = rep_inc;
                  if (repeat_limit_r != REPEAT_FOREVER && rep_inc > repeat_limit_r) begin
                    held_prio_nxt = '0;
                    active_nxt    = 1'b0;
                    ended         = 1'b1;
                  end else begin
                    restart_sound = 1'b1;
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end

    // fraction of the step survives a restart
    if (restart_freq || restart_sound) begin
      step_nxt  = {start_step_r, step_nxt[15:0]};
      slide_nxt = start_slide_r;
      phase_nxt = '0;
      half_nxt  = '0;
    end
    if (restart_sound) begin
      level_nxt     = LEVEL_MIN;
      amp_nxt       = '0;
      slope_nxt     = stage_slopes_r[15:0];
      target_nxt    = stage_times_r[15:0];
      stage_sum_nxt = '0;
      stage_idx_nxt = STAGE_ATTACK;
    end

    // amplitude carry moves the level after any stage change
    if (amp_step) begin
      amp_sum = amp_nxt + slope_nxt;
      amp_nxt = amp_sum;
      if (amp_sum < slope_nxt) begin
        if (stage_idx_nxt != STAGE_ATTACK) level_nxt = level_nxt - 8'd1;
        else                               level_nxt = level_nxt + 8'd1;
      end
    end

    res.half_period_done  = hp_done;
    res.half_period_ticks = hp_done ? half_inc : 16'd0;
    res.duty              = (level_nxt < LEVEL_MIN) ? LEVEL_MIN : level_nxt;
    res.playing           = active_nxt;
    res.note_done         = ended;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      held_prio_r <= '0;
      phase_r     <= '0;
      step_r      <= '0;
      slide_r     <= '0;
      level_r     <= LEVEL_MIN;
      amp_r       <= '0;
      slope_r     <= '0;
      stage_sum_r <= '0;
      target_r    <= '0;
      stage_idx_r <= STAGE_ATTACK;
      repeat_r    <= '0;
      half_r      <= '0;
    end else begin
      active_r    <= active_nxt;
      held_prio_r <= held_prio_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      slide_r     <= slide_nxt;
      level_r     <= level_nxt;
      amp_r       <= amp_nxt;
      slope_r     <= slope_nxt;
      stage_sum_r <= stage_sum_nxt;
      target_r    <= target_nxt;
      stage_idx_r <= stage_idx_nxt;
      repeat_r    <= repeat_nxt;
      half_r      <= half_nxt;
    end
  end

  // two-entry result buffer, head drives the port
  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        head_v_nxt = push;
        head_nxt   = res;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_v_nxt = 1'b1;
        head_nxt   = res;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid             = head_v_r;
  assign out_half_period_done  = head_r.half_period_done;
  assign out_half_period_ticks = head_r.half_period_ticks;
  assign out_duty              = head_r.duty;
  assign out_playing           = head_r.playing;
  assign out_note_done         = head_r.note_done;

  // skid entry is only ever filled behind a waiting head entry
  assert property (@(posedge clk) disable iff (!rst_n) skid_v_r |-> head_v_r)
    else $error("skid entry valid without head entry");

  // a note that just ended cannot still be sounding
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_note_done) |-> !out_playing)
    else $error("note_done reported while still playing");

  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && !out_half_period_done) |-> (out_half_period_ticks == 16'd0))
    else $error("half period ticks reported without half period end");

  // a silent voice cannot end a half period
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push && !active_r) |=> (!skid_v_r || !skid_r.half_period_done))
    else $error("half period ended while silent");

endmodule

/* tb/tone_envelope_generator_core_test.sv */
// ----------------------------------------------------------------------------
// tone_envelope_generator_core_test
// Drives tick, play, end and reserved transactions into the tone envelope
// generator under random idling and a long output hold-off. A predictor
// computes each result from its own copy of the note state and registers.
// Every result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tone_envelope_generator_core_test;
  import teg_pkg::*;

  localparam logic [1:0]  CMD_RESERVED = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PHASE_ITEMS  = 235;
  localparam int unsigned MAX_PRINTS   = 40;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] prio;
  } tone_cmd_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_command = CMD_TICK;
  logic [7:0]          in_priority_req = 8'd0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_half_period_done;
  logic [15:0]         out_half_period_ticks;
  logic [7:0]          out_duty;
  logic                out_playing;
  logic                out_note_done;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = REG_START_STEP;
  logic [CfgDataW-1:0] cfg_data = '0;

  tone_envelope_generator_core dut (.*);

  always #5 clk = ~clk;

  // predicted note state
  logic        note_on;
  logic [7:0]  held_prio, env_level, repeats_done;
  logic [15:0] phase_acc, amp_accum, cur_slope, stage_ticks, stage_goal, hp_count;
  logic [1:0]  stage_sel;
  logic [31:0] step_q, slide_q;

  // register copies
  logic [15:0] cfg_start_step;
  logic [31:0] cfg_start_slide, cfg_slide_delta, cfg_retrig;
  logic [47:0] cfg_stage_times, cfg_stage_slopes;
  logic [7:0]  cfg_repeat_limit;

  tone_cmd_t   queued_cmds[$];
  teg_result_t tone_results_due[$];
  tone_cmd_t   offer;
  teg_result_t due, want;

  logic        cmd_taken = 1'b0;
  logic        hold_on = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned half_periods = 0;
  int unsigned notes_ended = 0;
  int unsigned stalled_offers = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;

  function automatic void reload_pitch();
    step_q    = {cfg_start_step, step_q[15:0]};
    slide_q   = cfg_start_slide;
    phase_acc = '0;
    hp_count  = '0;
  endfunction

  function automatic void reload_note();
    reload_pitch();
    env_level    = LEVEL_MIN;
    amp_accum    = '0;
    cur_slope    = cfg_stage_slopes[15:0];
    stage_goal   = cfg_stage_times[15:0];
    stage_ticks  = '0;
    stage_sel    = STAGE_ATTACK;
    repeats_done = '0;
  endfunction

  function automatic void silence_note();
    held_prio = '0;
    note_on   = 1'b0;
  endfunction

  // true when the envelope has run out of repeats
  function automatic bit next_stage();
    logic [7:0] reps;
    stage_sel   = stage_sel + 2'd1;
    stage_ticks = '0;
    if (stage_sel == STAGE_SUSTAIN) begin
      env_level  = LEVEL_MAX;
      stage_goal = cfg_stage_times[31:16];
      cur_slope  = cfg_stage_slopes[31:16];
    end else if (stage_sel == STAGE_DECAY) begin
      stage_goal = cfg_stage_times[47:32];
      cur_slope  = cfg_stage_slopes[47:32];
    end else begin
      reps = repeats_done + 8'd1;
      repeats_done = reps;
      if (cfg_repeat_limit != REPEAT_FOREVER &&
          {1'b0, reps} >= {1'b0, cfg_repeat_limit} + 9'd1) begin
        silence_note();
        return 1'b1;
      end
      reload_note();
      repeats_done = reps;
    end
    return 1'b0;
  endfunction

  function automatic teg_result_t step_tone(input logic [1:0] cmd, input logic [7:0] prio);
    teg_result_t res;
    logic [15:0] whole, ticks, lo_lim, hi_lim;
    logic [31:0] slide_term;
    logic        ended;
    res   = '0;
    ended = 1'b0;
    case (cmd)
      CMD_PLAY: begin
        if (held_prio < prio) begin
          held_prio = prio;
          reload_note();
          note_on = 1'b1;
        end
      end
      CMD_END: begin
        ended = note_on;
        silence_note();
      end
      CMD_TICK: begin
        if (note_on) begin
          whole      = step_q[31:16];
          phase_acc  = phase_acc + whole;
          // arithmetic shift of the slide done by offsetting around the sign bit
          slide_term = (slide_q + 32'h8000_0000) >> 8;
          step_q     = step_q + slide_term - 32'h0080_0000;
          slide_q    = slide_q + cfg_slide_delta;
          hp_count   = hp_count + 16'd1;
          whole      = step_q[31:16];
          if (phase_acc < whole) begin
            ticks = hp_count;
            res.half_period_done  = 1'b1;
            res.half_period_ticks = ticks;
            stage_ticks = stage_ticks + ticks;
            lo_lim = cfg_retrig[15:0];
            hi_lim = cfg_retrig[31:16];
            if ((lo_lim != 16'd0 && whole <= lo_lim) || (hi_lim != 16'd0 && whole >= hi_lim))
              reload_pitch();
            hp_count = '0;
            if (stage_ticks >= stage_goal && next_stage())
              ended = 1'b1;
          end
          // amplitude still steps on the tick that ends the note
          amp_accum = amp_accum + cur_slope;
          if (amp_accum < cur_slope) begin
            if (stage_sel != STAGE_ATTACK) env_level = env_level - 8'd1;
            else env_level = env_level + 8'd1;
          end
        end
      end
      default: ;
    endcase
    res.duty      = (env_level < LEVEL_MIN) ? LEVEL_MIN : env_level;
    res.playing   = note_on;
    res.note_done = ended;
    return res;
  endfunction

  function automatic void clear_tone_model();
    note_on = 1'b0;  held_prio = '0;  env_level = LEVEL_MIN;  repeats_done = '0;
    phase_acc = '0;  amp_accum = '0;  cur_slope = '0;  stage_ticks = '0;
    stage_goal = '0;  hp_count = '0;  stage_sel = STAGE_ATTACK;
    step_q = '0;  slide_q = '0;
    cfg_start_step = '0;  cfg_start_slide = '0;  cfg_slide_delta = '0;  cfg_retrig = '0;
    cfg_stage_times = '0;  cfg_stage_slopes = '0;  cfg_repeat_limit = '0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               what, results_checked, got, exp_val);
  endtask

  // monitor: register mirror, result check, then prediction of the taken command
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tone_model();
      cmd_taken = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (teg_reg_t'(cfg_index))
          REG_START_STEP:    cfg_start_step   = cfg_data[15:0];
          REG_START_SLIDE:   cfg_start_slide  = cfg_data[31:0];
          REG_SLIDE_DELTA:   cfg_slide_delta  = cfg_data[31:0];
          REG_STAGE_TIMES:   cfg_stage_times  = cfg_data[47:0];
          REG_STAGE_SLOPES:  cfg_stage_slopes = cfg_data[47:0];
          REG_RETRIG_LIMITS: cfg_retrig       = cfg_data[31:0];
          REG_REPEAT_LIMIT:  cfg_repeat_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (tone_results_due.size() == 0) begin
          report_mismatch("unexpected transaction", 32'd0, 32'd0);
        end else begin
          want = tone_results_due.pop_front();
          if (out_half_period_done !== want.half_period_done)
            report_mismatch("half_period_done", out_half_period_done, want.half_period_done);
          if (out_half_period_ticks !== want.half_period_ticks)
            report_mismatch("half_period_ticks", out_half_period_ticks,
                            want.half_period_ticks);
          if (out_duty !== want.duty)
            report_mismatch("duty", out_duty, want.duty);
          if (out_playing !== want.playing)
            report_mismatch("playing", out_playing, want.playing);
          if (out_note_done !== want.note_done)
            report_mismatch("note_done", out_note_done, want.note_done);
        end
        results_checked++;
      end
      if (in_valid && in_stall) stalled_offers++;
      cmd_taken = in_valid && !in_stall;
      if (cmd_taken) begin
        due = step_tone(in_command, in_priority_req);
        tone_results_due.push_back(due);
        items_accepted++;
        if (due.half_period_done) half_periods++;
        if (due.note_done) notes_ended++;
      end
    end
  end

  // sender: a new command only once the offered one has gone
  always @(negedge clk) begin
    if (!in_valid || cmd_taken) begin
      if (rst_n && queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offer = queued_cmds.pop_front();
        in_valid        <= 1'b1;
        in_command      <= offer.cmd;
        in_priority_req <= offer.prio;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  // long hold-off on the result side so the buffer fills and the input stalls
  initial begin
    wait (items_accepted >= 300);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tone_envelope_generator_core_test: FAIL");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [1:0] cmd, input logic [7:0] prio);
    queued_cmds.push_back('{cmd: cmd, prio: prio});
    items_queued++;
  endtask

  task automatic write_reg(input teg_reg_t idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry noise, the block must ignore them
  task automatic apply_settings(input logic [15:0] step, input logic [31:0] slide,
                                input logic [31:0] delta, input logic [47:0] times,
                                input logic [47:0] slopes, input logic [31:0] retrig,
                                input logic [7:0] reps);
    write_reg(REG_START_STEP, {32'($urandom), step});
    write_reg(REG_START_SLIDE, {16'($urandom), slide});
    write_reg(REG_SLIDE_DELTA, {16'($urandom), delta});
    write_reg(REG_STAGE_TIMES, times);
    write_reg(REG_STAGE_SLOPES, slopes);
    write_reg(REG_RETRIG_LIMITS, {16'($urandom), retrig});
    write_reg(REG_REPEAT_LIMIT, {40'($urandom), reps});
    settings_used++;
  endtask

  task automatic random_settings(input int unsigned phase);
    logic [15:0] step, lo_lim, hi_lim;
    logic [31:0] slide, delta;
    logic [47:0] times;
    logic [7:0]  reps;
    step   = 16'($urandom_range(12000, 1500));
    slide  = $urandom_range(1 << 20) - (1 << 19);
    delta  = $urandom_range(2048) - 1024;
    times  = {16'($urandom_range(150)), 16'($urandom_range(150)), 16'($urandom_range(150))};
    lo_lim = ($urandom_range(1)) ? step >> 1 : 16'd0;
    hi_lim = ($urandom_range(1)) ? step + (step >> 1) : 16'd0;
    case ($urandom_range(4))
      0: reps = 8'd0;
      1: reps = 8'd1;
      2: reps = 8'd2;
      3: reps = 8'd3;
      default: reps = REPEAT_FOREVER;
    endcase
    if (phase == 2) reps = REPEAT_FOREVER;
    if (phase == 5) reps = 8'd0;
    apply_settings(step, slide, delta, times, {16'($urandom), 32'($urandom)},
                   {hi_lim, lo_lim}, reps);
  endtask

  // mostly whole notes: a play, a run of ticks with the odd interruption, then usually an end
  task automatic queue_random_traffic(input int unsigned budget);
    int unsigned target, run, k;
    target = items_queued + budget;
    while (items_queued < target) begin
      if ($urandom_range(99) < 85) begin
        queue_cmd(CMD_PLAY, 8'($urandom_range(255, 1)));
        run = $urandom_range(200, 10);
        for (k = 0; k < run && items_queued < target; k++) begin
          case ($urandom_range(49))
            0:       queue_cmd(CMD_PLAY, 8'($urandom));
            1:       queue_cmd(CMD_RESERVED, 8'($urandom));
            default: queue_cmd(CMD_TICK, 8'($urandom));
          endcase
        end
        if ($urandom_range(99) < 65) queue_cmd(CMD_END, 8'($urandom));
      end else begin
        run = $urandom_range(6, 1);
        for (k = 0; k < run && items_queued < target; k++)
          queue_cmd(2'($urandom_range(3)), 8'($urandom));
      end
    end
  endtask

  task automatic drain();
    while (items_accepted != items_queued || tone_results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_pace(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  initial begin
    int unsigned phase;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // extremes: fastest step, steepest slides, zero stage times, full slopes
    set_pace(0, 0);
    apply_settings(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 48'h0, 48'hFFFF_FFFF_FFFF,
                   32'hFFFF_FFFF, REPEAT_FOREVER);
    queue_cmd(CMD_TICK, 8'hFF);     // silent tick
    queue_cmd(CMD_END, 8'h00);      // end while silent
    queue_cmd(CMD_RESERVED, 8'hAA);
    queue_cmd(CMD_PLAY, 8'h00);     // priority zero never loads
    queue_cmd(CMD_PLAY, 8'hFF);
    queue_cmd(CMD_PLAY, 8'hFF);     // not above the held priority
    queue_cmd(CMD_PLAY, 8'h01);
    for (int i = 0; i < 6; i++) queue_cmd(CMD_TICK, (i % 2) ? 8'hFF : 8'h00);
    queue_cmd(CMD_RESERVED, 8'h55);
    queue_cmd(CMD_TICK, 8'h00);
    queue_cmd(CMD_END, 8'hFF);
    queue_cmd(CMD_END, 8'h00);
    drain();

    // opposite extremes: zero step, most negative slide, longest stages, no repeats
    apply_settings(16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0,
                   32'h0, 8'd0);
    queue_cmd(CMD_PLAY, 8'h01);
    for (int i = 0; i < 4; i++) queue_cmd(CMD_TICK, 8'h00);
    queue_cmd(CMD_PLAY, 8'h80);     // higher priority takes over
    queue_cmd(CMD_TICK, 8'h00);
    queue_cmd(CMD_END, 8'h00);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      if (phase < 2) set_pace(25, 69);
      else if (phase < 4) set_pace(69, 25);
      else set_pace(0, 0);
      random_settings(phase);
      queue_random_traffic(PHASE_ITEMS);
      drain();
    end
    repeat (8) @(negedge clk);

    while (tone_results_due.size() != 0) begin
      want = tone_results_due.pop_front();
      report_mismatch("missing transaction", 32'd0, {31'd0, want.half_period_done});
    end
    $display("covered %0d transactions under %0d register settings, %0d results checked",
             items_accepted, settings_used, results_checked);
    $display("predicted %0d half periods and %0d note ends; input stalled %0d cycles",
             half_periods, notes_ended, stalled_offers);
    if (mismatches == 0) begin
      $display("tone_envelope_generator_core_test: PASS");
    end else begin
      $display("tone_envelope_generator_core_test: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/teg_pkg.sv
rtl/core/tone_envelope_generator_core.sv
tb/tone_envelope_generator_core_test.sv
